@@ sv/uflm_pkg.sv @@
// ----------------------------------------------------------------------------
// uflm_pkg
// shared types and constants for the ultrasonic frame level monitor
// ----------------------------------------------------------------------------
package uflm_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned DIST_W      = 16;
    localparam int unsigned BYTE_W      = 8;

    localparam int unsigned TIMER_WIDTH_DEFAULT = 16;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;

    // register reset values
    localparam logic [CFG_W-1:0] ZERO_DIST_RST = 16'd0;
    localparam logic [CFG_W-1:0] MIN_DIST_RST  = 16'd280;
    localparam logic [CFG_W-1:0] MAX_DIST_RST  = 16'd2500;
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] GRACE_RST     = 16'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_DIST = 3'd0,
        REG_MIN_DIST  = 3'd1,
        REG_MAX_DIST  = 3'd2,
        REG_TIMEOUT   = 3'd3,
        REG_GRACE     = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAT_NONE  = 2'd0,
        STAT_OK    = 2'd1,
        STAT_CSUM  = 2'd2,
        STAT_RANGE = 2'd3
    } frame_status_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

endpackage

@@ sv/uflm_in_if.sv @@
// ----------------------------------------------------------------------------
// uflm_in_if
// input channel: one received byte or one millisecond tick per beat
// ----------------------------------------------------------------------------
interface uflm_in_if;

    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [uflm_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);

endinterface

@@ sv/uflm_out_if.sv @@
// ----------------------------------------------------------------------------
// uflm_out_if
// result channel: held reading and frame status, one beat per input beat
// ----------------------------------------------------------------------------
interface uflm_out_if;

    logic                          valid;
    logic                          ready;
    logic [uflm_pkg::DIST_W-1:0]   distance_mm;
    logic [uflm_pkg::DIST_W-1:0]   water_level_mm;
    logic                          reading_valid;
    logic                          sensor_detected;
    logic [1:0]                    frame_status;

    modport source (
        output valid, output distance_mm, output water_level_mm,
        output reading_valid, output sensor_detected, output frame_status,
        input  ready
    );
    modport sink (
        input  valid, input distance_mm, input water_level_mm,
        input  reading_valid, input sensor_detected, input frame_status,
        output ready
    );

endinterface

@@ sv/ultrasonic_frame_level_monitor.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_frame_level_monitor
// timing: a result beat is registered and valid in the cycle after its input beat is taken
// throughput: one input beat per cycle; the single result register frees
//   itself in the same cycle it is taken, so input ready follows output ready
// reset: rst_n clears the frame parser, held reading, flags and both timers,
//   and loads the register defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
module ultrasonic_frame_level_monitor #(
    parameter int unsigned TIMER_WIDTH = uflm_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uflm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uflm_pkg::CFG_W-1:0]      cfg_data,
    uflm_in_if.sink                         item,
    uflm_out_if.source                      result
);

    // compare width wide enough for both a timer and a 16-bit limit
    localparam int unsigned CMP_W =
        (TIMER_WIDTH > uflm_pkg::CFG_W) ? TIMER_WIDTH : uflm_pkg::CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    // frame parser position
    typedef enum logic [1:0] {
        POS_HUNT = 2'd0,
        POS_HIGH = 2'd1,
        POS_LOW  = 2'd2,
        POS_SUM  = 2'd3
    } pos_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [uflm_pkg::CFG_W-1:0] zero_dist_reg;
    logic [uflm_pkg::CFG_W-1:0] min_dist_reg;
    logic [uflm_pkg::CFG_W-1:0] max_dist_reg;
    logic [uflm_pkg::CFG_W-1:0] timeout_reg;
    logic [uflm_pkg::CFG_W-1:0] grace_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_dist_reg <= uflm_pkg::ZERO_DIST_RST;
            min_dist_reg  <= uflm_pkg::MIN_DIST_RST;
            max_dist_reg  <= uflm_pkg::MAX_DIST_RST;
            timeout_reg   <= uflm_pkg::TIMEOUT_RST;
            grace_reg     <= uflm_pkg::GRACE_RST;
        end
        else if (cfg_we)
        begin
            // indexes past the list are dropped
            unique case (cfg_index)
                uflm_pkg::REG_ZERO_DIST: zero_dist_reg <= cfg_data;
                uflm_pkg::REG_MIN_DIST:  min_dist_reg  <= cfg_data;
                uflm_pkg::REG_MAX_DIST:  max_dist_reg  <= cfg_data;
                uflm_pkg::REG_TIMEOUT:   timeout_reg   <= cfg_data;
                uflm_pkg::REG_GRACE:     grace_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor state
    // ------------------------------------------------------------------
    pos_t                             pos_reg,        pos_next;
    logic [uflm_pkg::BYTE_W-1:0]      high_reg,       high_next;
    logic [uflm_pkg::BYTE_W-1:0]      low_reg,        low_next;
    logic [uflm_pkg::DIST_W-1:0]      dist_reg,       dist_next;
    logic [uflm_pkg::DIST_W-1:0]      level_reg,      level_next;
    logic                             valid_flag_reg, valid_flag_next;
    logic                             detected_reg,   detected_next;
    logic                             ever_valid_reg, ever_valid_next;
    logic [TIMER_WIDTH-1:0]           since_valid_reg, since_valid_next;
    logic [TIMER_WIDTH-1:0]           since_reset_reg, since_reset_next;
    uflm_pkg::frame_status_t          status_next;

    // result register (the skid between input and output sides)
    logic                             out_valid_reg;
    logic [uflm_pkg::DIST_W-1:0]      out_dist_reg;
    logic [uflm_pkg::DIST_W-1:0]      out_level_reg;
    logic                             out_rvalid_reg;
    logic                             out_detected_reg;
    uflm_pkg::frame_status_t          out_status_reg;

    logic item_fire;

    // a new beat is taken whenever the result slot is empty or draining
    assign item.ready = !out_valid_reg || result.ready;
    assign item_fire  = item.valid && item.ready;

    // frame decode helpers
    logic [uflm_pkg::BYTE_W-1:0]  csum;
    logic [uflm_pkg::DIST_W-1:0]  frame_dist;
    logic                         in_range;

    assign csum       = uflm_pkg::HEADER_BYTE + high_reg + low_reg;
    assign frame_dist = {high_reg, low_reg};
    assign in_range   = (frame_dist >= min_dist_reg) && (frame_dist <= max_dist_reg);

    // timers after the tick, and their threshold checks
    logic [TIMER_WIDTH-1:0] valid_bump;
    logic [TIMER_WIDTH-1:0] reset_bump;
    logic                   timeout_hit;
    logic                   grace_hit;
    logic                   stale;

    assign valid_bump = (since_valid_reg == TIMER_MAX) ? TIMER_MAX
                                                        : since_valid_reg + 1'b1;
    assign reset_bump = (since_reset_reg == TIMER_MAX) ? TIMER_MAX
                                                        : since_reset_reg + 1'b1;

    // a saturated timer reaches every threshold
    assign timeout_hit = (CMP_W'(valid_bump) >= CMP_W'(timeout_reg))
                      || (valid_bump == TIMER_MAX);
    assign grace_hit   = (CMP_W'(reset_bump) >= CMP_W'(grace_reg))
                      || (reset_bump == TIMER_MAX);
    assign stale       = !ever_valid_reg || timeout_hit;

    always_comb
    begin
        pos_next         = pos_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        dist_next        = dist_reg;
        level_next       = level_reg;
        valid_flag_next  = valid_flag_reg;
        detected_next    = detected_reg;
        ever_valid_next  = ever_valid_reg;
        since_valid_next = since_valid_reg;
        since_reset_next = since_reset_reg;
        status_next      = uflm_pkg::STAT_NONE;

        if (item.op == uflm_pkg::OP_BYTE)
        begin
            unique case (pos_reg)
                POS_HUNT:
                begin
                    if (item.rx_byte == uflm_pkg::HEADER_BYTE)
                        pos_next = POS_HIGH;
                end
                POS_HIGH:
                begin
                    high_next = item.rx_byte;
                    pos_next  = POS_LOW;
                end
                POS_LOW:
                begin
                    low_next = item.rx_byte;
                    pos_next = POS_SUM;
                end
                POS_SUM:
                begin
                    // frame done either way, back to hunting
                    pos_next = POS_HUNT;
                    priority if (csum != item.rx_byte)
                    begin
                        status_next = uflm_pkg::STAT_CSUM;
                    end
                    else if (!in_range)
                    begin
                        status_next = uflm_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        status_next      = uflm_pkg::STAT_OK;
                        dist_next        = frame_dist;
                        level_next       = (zero_dist_reg > frame_dist)
                                         ? zero_dist_reg - frame_dist : '0;
                        valid_flag_next  = 1'b1;
                        detected_next    = 1'b1;
                        ever_valid_next  = 1'b1;
                        since_valid_next = '0;
                    end
                end
            endcase
        end
        else
        begin
            // tick: age timers, then drop a stale reading and, past the grace time, the detected flag
            since_valid_next = valid_bump;
            since_reset_next = reset_bump;
            if (stale)
            begin
                dist_next       = '0;
                level_next      = '0;
                valid_flag_next = 1'b0;
                if (grace_hit)
                    detected_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_HUNT;
            high_reg        <= '0;
            low_reg         <= '0;
            dist_reg        <= '0;
            level_reg       <= '0;
            valid_flag_reg  <= 1'b0;
            detected_reg    <= 1'b0;
            ever_valid_reg  <= 1'b0;
            since_valid_reg <= '0;
            since_reset_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                pos_reg         <= pos_next;
                high_reg        <= high_next;
                low_reg         <= low_next;
                dist_reg        <= dist_next;
                level_reg       <= level_next;
                valid_flag_reg  <= valid_flag_next;
                detected_reg    <= detected_next;
                ever_valid_reg  <= ever_valid_next;
                since_valid_reg <= since_valid_next;
                since_reset_reg <= since_reset_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            out_dist_reg     <= dist_next;
            out_level_reg    <= level_next;
            out_rvalid_reg   <= valid_flag_next;
            out_detected_reg <= detected_next;
            out_status_reg   <= status_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.distance_mm     = out_dist_reg;
    assign result.water_level_mm  = out_level_reg;
    assign result.reading_valid   = out_rvalid_reg;
    assign result.sensor_detected = out_detected_reg;
    assign result.frame_status    = out_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an invalid reading always reports zero distance and level
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.reading_valid)
            |-> (result.distance_mm == '0 && result.water_level_mm == '0))
        else $error("invalid reading with nonzero distance or level");

    // an accepted frame leaves the reading valid and the sensor detected
    a_ok_sets_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frame_status == uflm_pkg::STAT_OK)
            |-> (result.reading_valid && result.sensor_detected))
        else $error("accepted frame without valid and detected");

    // valid reading can only be held by a detected sensor
    a_valid_implies_detected: assert property (@(posedge clk) disable iff (!rst_n)
        valid_flag_reg |-> detected_reg)
        else $error("reading valid while sensor not detected");

    // a tick beat produces a result with no frame status on the next cycle
    a_tick_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.op == uflm_pkg::OP_TICK)
            |=> (result.valid && result.frame_status == uflm_pkg::STAT_NONE))
        else $error("tick beat reported a frame status");

endmodule
